[rtl/decimal_string_to_int_checker_macros.svh]
// Assertion macros shared by the decimal string checker RTL.
// Each macro expands to one labelled concurrent assertion on clk, idle in reset.
`ifndef DECIMAL_STRING_TO_INT_CHECKER_MACROS_SVH
`define DECIMAL_STRING_TO_INT_CHECKER_MACROS_SVH

// Same-cycle implication.
`define DSIC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decimal string checker: same-cycle check failed");

// Next-cycle implication.
`define DSIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decimal string checker: next-cycle check failed");

`endif

[rtl/dsic_pkg.sv]
// Package for the decimal string checker: character codes, status codes,
// classified character record and queue constants. No dependencies.
`timescale 1ns / 1ps

package dsic_pkg;

    // ASCII codes of interest.
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_BAD_CHAR    = 3'd2,
        ST_SIGN_MISUSE = 3'd3,
        ST_LONE_SIGN   = 3'd4
    } status_t;

    // Character classes.
    typedef enum logic [2:0] {
        K_DIGIT = 3'd0,
        K_PLUS  = 3'd1,
        K_MINUS = 3'd2,
        K_SPACE = 3'd3,
        K_BAD   = 3'd4
    } char_kind_t;

    // One classified request as it travels through the queue.
    typedef struct packed {
        char_kind_t  kind;
        logic [3:0]  digit;
        logic        is_last;
        logic        no_char;
    } entry_t;

    // Queue status seen by the back end and the top level.
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_stat_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

[rtl/dsic_if.sv]
// Handshake channels of the decimal string checker: character requests in,
// conversion results out. No dependencies.
`timescale 1ns / 1ps

interface dsic_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;
    logic       no_char;

    modport source (output valid, output char_code, output is_last, output no_char,
                    input ready);
    modport sink   (input valid, input char_code, input is_last, input no_char,
                    output ready);
endinterface

interface dsic_result_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          overflow;

    modport source (output valid, output status, output value, output overflow,
                    input ready);
    modport sink   (input valid, input status, input value, input overflow,
                    output ready);
endinterface

[rtl/dsic_front.sv]
// Front end of the decimal string checker: classifies each incoming character.
// Depends on dsic_pkg.
`timescale 1ns / 1ps

module dsic_front (
    input  logic [7:0]      char_code,
    input  logic            is_last,
    input  logic            no_char,
    output dsic_pkg::entry_t entry
);
    import dsic_pkg::*;

    // Sort the byte into digit, sign, space or anything else.
    always_comb
    begin
        entry.is_last = is_last;
        entry.no_char = no_char;
        entry.digit   = char_code[3:0];
        if (char_code inside {[CH_ZERO:CH_NINE]})
        begin
            entry.kind = K_DIGIT;
        end
        else if (char_code == CH_PLUS)
        begin
            entry.kind = K_PLUS;
        end
        else if (char_code == CH_MINUS)
        begin
            entry.kind = K_MINUS;
        end
        else if (char_code == CH_SPACE)
        begin
            entry.kind = K_SPACE;
        end
        else
        begin
            entry.kind = K_BAD;
        end
    end

endmodule

[rtl/dsic_queue.sv]
// Short queue of classified characters between front and back end.
// Depends on dsic_pkg.
`timescale 1ns / 1ps

module dsic_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dsic_pkg::entry_t      push_entry,
    input  logic                  pop,
    output dsic_pkg::entry_t      head,
    output dsic_pkg::queue_stat_t stat
);
    import dsic_pkg::*;

    entry_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign stat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign head           = slots_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && stat.not_empty;

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/dsic_back.sv]
// Back end of the decimal string checker: parse state, accumulator, status
// evaluation and result register. Depends on dsic_pkg and dsic_if.
`timescale 1ns / 1ps

module dsic_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsic_pkg::entry_t      head,
    input  dsic_pkg::queue_stat_t stat,
    output logic                  pop,
    dsic_result_if.source         results
);
    import dsic_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,
        PH_RUN  = 3'b010,
        PH_STOP = 3'b100
    } phase_t;

    localparam int ACC_W = VALUE_WIDTH + 4;
    localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] POS_MAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // Parse state.
    phase_t                  phase_reg, phase_next;
    logic [1:0]              char_count_reg, char_count_next;
    logic                    all_spaces_reg, all_spaces_next;
    logic                    bad_char_reg, bad_char_next;
    logic [1:0]              plus_count_reg, plus_count_next;
    logic [1:0]              minus_count_reg, minus_count_next;
    logic                    first_sign_reg, first_sign_next;
    logic                    misplaced_reg, misplaced_next;
    logic                    negative_reg, negative_next;
    logic [VALUE_WIDTH-1:0]  mag_reg, mag_next;
    logic                    ovf_reg, ovf_next;

    // Finished string, waiting for the value to be formed.
    logic                    fin_valid_reg, fin_valid_next;
    status_t                 fin_status_reg, fin_status_next;
    logic                    fin_negative_reg, fin_negative_next;
    logic [VALUE_WIDTH-1:0]  fin_mag_reg, fin_mag_next;
    logic                    fin_ovf_reg, fin_ovf_next;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic [2:0]              out_status_reg;
    logic [VALUE_WIDTH-1:0]  out_value_reg, out_value_next;
    logic                    out_ovf_reg, out_ovf_next;

    logic                    out_free;
    logic                    fin_free;
    logic                    fin_move;
    logic [ACC_W-1:0]        acc_sum;
    logic                    acc_big;
    logic                    is_sign;

    assign out_free = !out_valid_reg || results.ready;
    assign fin_free = !fin_valid_reg || out_free;
    assign fin_move = fin_valid_reg && out_free;
    assign pop      = stat.not_empty && (!head.is_last || fin_free);
    assign is_sign  = (head.kind == K_PLUS) || (head.kind == K_MINUS);

    // magnitude * 10 + digit, and whether it passes the magnitude limit.
    assign acc_sum = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                   + {{VALUE_WIDTH{1'b0}}, head.digit};
    assign acc_big = ovf_reg || (acc_sum > {4'b0, MAG_LIMIT});

    // Character step, then status on the last request of a string.
    always_comb
    begin
        phase_next        = phase_reg;
        char_count_next   = char_count_reg;
        all_spaces_next   = all_spaces_reg;
        bad_char_next     = bad_char_reg;
        plus_count_next   = plus_count_reg;
        minus_count_next  = minus_count_reg;
        first_sign_next   = first_sign_reg;
        misplaced_next    = misplaced_reg;
        negative_next     = negative_reg;
        mag_next          = mag_reg;
        ovf_next          = ovf_reg;
        fin_valid_next    = fin_move ? 1'b0 : fin_valid_reg;
        fin_status_next   = fin_status_reg;
        fin_negative_next = fin_negative_reg;
        fin_mag_next      = fin_mag_reg;
        fin_ovf_next      = fin_ovf_reg;

        if (pop && !head.no_char)
        begin
            if (char_count_reg == 2'd0 && is_sign)
            begin
                first_sign_next = 1'b1;
            end
            if (char_count_reg != 2'd2)
            begin
                char_count_next = char_count_reg + 2'd1;
            end
            if (head.kind != K_SPACE)
            begin
                all_spaces_next = 1'b0;
            end
            if (head.kind == K_BAD)
            begin
                bad_char_next = 1'b1;
            end
            if (head.kind == K_PLUS && plus_count_reg != 2'd2)
            begin
                plus_count_next = plus_count_reg + 2'd1;
            end
            if (head.kind == K_MINUS && minus_count_reg != 2'd2)
            begin
                minus_count_next = minus_count_reg + 2'd1;
            end

            case (phase_reg)
                PH_LEAD:
                begin
                    if (is_sign)
                    begin
                        negative_next = (head.kind == K_MINUS);
                        phase_next    = PH_RUN;
                    end
                    else if (head.kind == K_DIGIT)
                    begin
                        mag_next   = acc_big ? MAG_LIMIT : acc_sum[VALUE_WIDTH-1:0];
                        ovf_next   = acc_big;
                        phase_next = PH_RUN;
                    end
                end
                PH_RUN:
                begin
                    if (head.kind == K_SPACE)
                    begin
                        phase_next = PH_STOP;
                    end
                    else if (is_sign)
                    begin
                        misplaced_next = 1'b1;
                    end
                    else if (head.kind == K_DIGIT && !misplaced_reg)
                    begin
                        mag_next = acc_big ? MAG_LIMIT : acc_sum[VALUE_WIDTH-1:0];
                        ovf_next = acc_big;
                    end
                end
                default:
                begin
                    // Stopped: characters are only checked.
                end
            endcase
        end

        if (pop && head.is_last)
        begin
            fin_valid_next    = 1'b1;
            fin_negative_next = negative_next;
            fin_mag_next      = mag_next;
            fin_ovf_next      = ovf_next;
            if (all_spaces_next)
            begin
                fin_status_next = ST_EMPTY;
            end
            else if (bad_char_next)
            begin
                fin_status_next = ST_BAD_CHAR;
            end
            else if (plus_count_next == 2'd2 || minus_count_next == 2'd2)
            begin
                fin_status_next = ST_SIGN_MISUSE;
            end
            else if (char_count_next == 2'd1 && first_sign_next)
            begin
                fin_status_next = ST_LONE_SIGN;
            end
            else if (misplaced_next)
            begin
                fin_status_next = ST_SIGN_MISUSE;
            end
            else
            begin
                fin_status_next = ST_OK;
            end

            // Back to the start for the next string.
            phase_next       = PH_LEAD;
            char_count_next  = 2'd0;
            all_spaces_next  = 1'b1;
            bad_char_next    = 1'b0;
            plus_count_next  = 2'd0;
            minus_count_next = 2'd0;
            first_sign_next  = 1'b0;
            misplaced_next   = 1'b0;
            negative_next    = 1'b0;
            mag_next         = '0;
            ovf_next         = 1'b0;
        end
    end

    // Signed value with saturation; errors give zero.
    always_comb
    begin
        out_valid_next = fin_move ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
        out_value_next = '0;
        out_ovf_next   = 1'b0;
        if (fin_status_reg == ST_OK)
        begin
            if (fin_negative_reg)
            begin
                out_value_next = '0 - fin_mag_reg;
                out_ovf_next   = fin_ovf_reg;
            end
            else if (fin_mag_reg >= MAG_LIMIT)
            begin
                out_value_next = POS_MAX;
                out_ovf_next   = 1'b1;
            end
            else
            begin
                out_value_next = fin_mag_reg;
                out_ovf_next   = fin_ovf_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            char_count_reg  <= 2'd0;
            all_spaces_reg  <= 1'b1;
            bad_char_reg    <= 1'b0;
            plus_count_reg  <= 2'd0;
            minus_count_reg <= 2'd0;
            first_sign_reg  <= 1'b0;
            misplaced_reg   <= 1'b0;
            negative_reg    <= 1'b0;
            mag_reg         <= '0;
            ovf_reg         <= 1'b0;
            fin_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            char_count_reg  <= char_count_next;
            all_spaces_reg  <= all_spaces_next;
            bad_char_reg    <= bad_char_next;
            plus_count_reg  <= plus_count_next;
            minus_count_reg <= minus_count_next;
            first_sign_reg  <= first_sign_next;
            misplaced_reg   <= misplaced_next;
            negative_reg    <= negative_next;
            mag_reg         <= mag_next;
            ovf_reg         <= ovf_next;
            fin_valid_reg   <= fin_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        fin_status_reg   <= fin_status_next;
        fin_negative_reg <= fin_negative_next;
        fin_mag_reg      <= fin_mag_next;
        fin_ovf_reg      <= fin_ovf_next;
        if (fin_move)
        begin
            out_status_reg <= fin_status_reg;
            out_value_reg  <= out_value_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.status   = out_status_reg;
    assign results.value    = out_value_reg;
    assign results.overflow = out_ovf_reg;

endmodule

[rtl/decimal_string_to_int_checker.sv]
// Top level of the decimal string checker: front classifier, queue, back end.
// Depends on dsic_pkg, dsic_if, dsic_front, dsic_queue, dsic_back and the macros header.
//
//   channel   direction  carries                             one request is
//   chars     in         char_code, is_last, no_char         one character
//   results   out        status, value, overflow             one finished string
//
// One character is taken per cycle, sustained while chars.ready is high; the parse state update in the
// back end is a single step (one shift-add and compare) per character.
// A result passes through the queue, the finished-string register and the result register when nothing waits ahead.
// Reset is asynchronous and active low; it empties the queue and clears parse state.
// chars.ready drops only when the two-entry queue is full, which happens when
// results stalls long enough for a finished string to back up into the queue.
`timescale 1ns / 1ps

`include "decimal_string_to_int_checker_macros.svh"

module decimal_string_to_int_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    dsic_char_if.sink     chars,
    dsic_result_if.source results
);
    import dsic_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] POS_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    entry_t      front_entry;
    entry_t      head;
    queue_stat_t q_stat;
    logic        pop;
    logic        err_result;
    logic        pos_ovf_result;

    // Classify incoming characters.
    dsic_front u_front (
        .char_code (chars.char_code),
        .is_last   (chars.is_last),
        .no_char   (chars.no_char),
        .entry     (front_entry)
    );

    // Decouple front from back.
    assign chars.ready = !q_stat.full;

    dsic_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (chars.valid),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    // Parse, accumulate and report.
    dsic_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .stat    (q_stat),
        .pop     (pop),
        .results (results)
    );

    // Kinds of result that the checks below look at.
    assign err_result     = results.valid && (results.status != ST_OK);
    assign pos_ovf_result = results.valid && (results.status == ST_OK) && results.overflow
                            && !results.value[VALUE_WIDTH-1];

    // Error results carry a zero value and no overflow.
    `DSIC_ASSERT_IMPL(a_error_zero, err_result, results.value == '0 && !results.overflow)
    // A positive overflowed result is the largest positive value.
    `DSIC_ASSERT_IMPL(a_pos_sat, pos_ovf_result, results.value == POS_MAX)
    // An accepted character is queued in the next cycle.
    `DSIC_ASSERT_NEXT(a_queued, chars.valid && chars.ready, q_stat.not_empty)
    // Nothing is taken from an empty queue.
    `DSIC_ASSERT_IMPL(a_no_pop_empty, pop, q_stat.not_empty)

endmodule
